### design/pst_pkg.sv
package pst_pkg;

    localparam int MAX_KEYWORD_LEN_DEF = 9;
    localparam int KW_COUNT = 21;

    localparam logic [5:0] K_IDENT = 6'd21;
    localparam logic [5:0] K_INT   = 6'd22;
    localparam logic [5:0] K_CHAR  = 6'd23;
    localparam logic [5:0] K_STR   = 6'd24;
    localparam logic [5:0] K_ASSIGN = 6'd25;
    localparam logic [5:0] K_COLON = 6'd26;
    localparam logic [5:0] K_LE    = 6'd27;
    localparam logic [5:0] K_NE    = 6'd28;
    localparam logic [5:0] K_LT    = 6'd29;
    localparam logic [5:0] K_GE    = 6'd30;
    localparam logic [5:0] K_GT    = 6'd31;
    localparam logic [5:0] K_SYM0  = 6'd32;
    localparam logic [5:0] K_ERROR = 6'd44;
    localparam logic [5:0] K_END   = 6'd45;

    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_NO_DQ    = 3'd1;
    localparam logic [2:0] E_BAD_CHAR = 3'd2;
    localparam logic [2:0] E_NO_SQ    = 3'd3;
    localparam logic [2:0] E_UNKNOWN  = 3'd4;
    localparam logic [2:0] E_OVERFLOW = 3'd5;

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_WORD    = 4'd1;
    localparam logic [3:0] M_NUM     = 4'd2;
    localparam logic [3:0] M_COLON   = 4'd3;
    localparam logic [3:0] M_LESS    = 4'd4;
    localparam logic [3:0] M_GREATER = 4'd5;
    localparam logic [3:0] M_STR     = 4'd6;
    localparam logic [3:0] M_CQ_OPEN = 4'd7;
    localparam logic [3:0] M_CQ_GOT  = 4'd8;

    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [30:0] number_value;
        logic [7:0]  char_value;
        logic [7:0]  text_length;
        logic [15:0] line_number;
        logic [2:0]  error_code;
        logic        last;
    } t_out_item;

    // Keyword text, up to nine letters padded with zero bytes, first letter in the high byte.
    function automatic logic [71:0] kw_text(input logic [4:0] k);
        logic [71:0] t;
        t = '0;
        case (k)
            5'd0:  t = {"array", 32'h0};
            5'd1:  t = {"begin", 32'h0};
            5'd2:  t = {"char", 40'h0};
            5'd3:  t = {"const", 32'h0};
            5'd4:  t = {"do", 56'h0};
            5'd5:  t = {"downto", 24'h0};
            5'd6:  t = {"else", 40'h0};
            5'd7:  t = {"end", 48'h0};
            5'd8:  t = {"for", 48'h0};
            5'd9:  t = {"function", 8'h0};
            5'd10: t = {"ident", 32'h0};
            5'd11: t = {"if", 56'h0};
            5'd12: t = {"integer", 16'h0};
            5'd13: t = {"of", 56'h0};
            5'd14: t = "procedure";
            5'd15: t = {"read", 40'h0};
            5'd16: t = {"then", 40'h0};
            5'd17: t = {"to", 56'h0};
            5'd18: t = {"var", 48'h0};
            5'd19: t = {"while", 32'h0};
            5'd20: t = {"write", 32'h0};
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [7:0] kw_len(input logic [4:0] k);
        logic [7:0] l;
        l = 8'd0;
        case (k)
            5'd4, 5'd11, 5'd13, 5'd17: l = 8'd2;
            5'd7, 5'd8, 5'd18: l = 8'd3;
            5'd2, 5'd6, 5'd15, 5'd16: l = 8'd4;
            5'd0, 5'd1, 5'd3, 5'd10, 5'd19, 5'd20: l = 8'd5;
            5'd5: l = 8'd6;
            5'd12: l = 8'd7;
            5'd9: l = 8'd8;
            5'd14: l = 8'd9;
            default: l = 8'd0;
        endcase
        return l;
    endfunction

endpackage

### design/pst_if.sv
interface pst_in_if import pst_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pst_out_if import pst_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/pst_kw_match.sv
module pst_kw_match import pst_pkg::*; #(
    parameter int MAX_KEYWORD_LEN = MAX_KEYWORD_LEN_DEF
) (
    input  logic [MAX_KEYWORD_LEN-1:0][7:0] i_prefix,
    input  logic [7:0]                      i_length,
    output logic [5:0]                      o_kind
);
    // Keyword text is compared byte by byte; bytes past the word are zero in both.
    always_comb begin
        logic [71:0] t;
        logic        hit;
        o_kind = K_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            t = kw_text(5'(k));
            hit = (kw_len(5'(k)) == i_length);
            for (int b = 0; b < 9; b++) begin
                if (i_prefix[b] != t[71 - 8*b -: 8]) hit = 1'b0;
            end
            for (int b = 9; b < MAX_KEYWORD_LEN; b++) begin
                if (i_prefix[b] != 8'd0) hit = 1'b0;
            end
            if (hit) o_kind = 6'(k);
        end
    end
endmodule

### design/pascal_subset_tokenizer_unit.sv
// Results are registered; the first result of an item appears in the cycle after
// it is accepted. One item per cycle while the output is taken each cycle and no
// item yields two results; such an item blocks intake until its first result is taken.
// Reset: i_rst_n is synchronous and active low; it empties the output register
// and returns the lexer to idle with line count zero.
module pascal_subset_tokenizer_unit import pst_pkg::*; #(
    parameter int MAX_KEYWORD_LEN = MAX_KEYWORD_LEN_DEF
) (
    input logic   i_clk,
    input logic   i_rst_n,
    pst_in_if.sink    i_in,
    pst_out_if.source o_out
);
    // Lexer state.
    logic [3:0]                      r_mode, n_mode;
    logic [MAX_KEYWORD_LEN-1:0][7:0] r_prefix, n_prefix;
    logic [7:0]                      r_len, n_len;
    logic [30:0]                     r_acc, n_acc;
    logic                            r_ovf, n_ovf;
    logic [7:0]                      r_lit, n_lit;
    logic [15:0]                     r_line, n_line;

    // Output register with a second slot for the second result of an item.
    logic      r_v0, r_v1;
    t_out_item r_o0, r_o1;

    logic [5:0] w_kw;
    pst_kw_match #(.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)) u_kw (
        .i_prefix(r_prefix), .i_length(r_len), .o_kind(w_kw)
    );

    // The unit takes an item when the second slot is free and the first will be free.
    logic w_acc;
    assign i_in.ready = !r_v1 && (!r_v0 || o_out.ready);
    assign w_acc = i_in.valid && i_in.ready;
    assign o_out.valid = r_v0;
    assign o_out.data = r_o0;

    logic [7:0] c;
    logic is_let, is_dig, is_ws, is_prn;
    logic [7:0] c_low;
    logic [15:0] w_ln;
    logic [34:0] w_mul;
    logic [35:0] w_sum;
    assign c = i_in.data.char_code;
    assign is_let = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    assign is_dig = c >= "0" && c <= "9";
    assign is_ws = (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
    assign is_prn = c == 8'd32 || c == 8'd33 || (c >= 8'd35 && c <= 8'd126);
    assign c_low = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    assign w_ln = (r_line == 16'hFFFF) ? r_line : r_line + 16'd1;
    // acc*10 = acc*8 + acc*2
    assign w_mul = {1'b0, r_acc, 3'b0} + {3'b0, r_acc, 1'b0};
    assign w_sum = {1'b0, w_mul} + {32'd0, c[3:0]};

    function automatic t_out_item mk(input logic [5:0] k, input logic [30:0] nv,
                                     input logic [7:0] cv, input logic [7:0] ln,
                                     input logic [2:0] e, input logic [15:0] l);
        t_out_item o;
        o.token_kind = k;
        o.number_value = nv;
        o.char_value = cv;
        o.text_length = ln;
        o.line_number = l;
        o.error_code = e;
        o.last = 1'b0;
        return o;
    endfunction

    t_out_item w_r [2];
    logic [1:0] w_n;
    logic [7:0] w_lenp;

    always_comb begin
        t_out_item fl, st;
        logic      fl_v, st_v, do_flush, do_idle;
        logic [15:0] ln_after;
        n_mode = r_mode; n_prefix = r_prefix; n_len = r_len; n_acc = r_acc;
        n_ovf = r_ovf; n_lit = r_lit; n_line = r_line;
        w_lenp = (r_len == 8'd255) ? r_len : r_len + 8'd1;
        fl = mk(K_ERROR, '0, 8'd0, 8'd0, E_NONE, w_ln);
        fl_v = 1'b1;
        st = mk(K_ERROR, '0, 8'd0, 8'd0, E_UNKNOWN, w_ln);
        st_v = 1'b0;
        do_flush = 1'b0;
        do_idle = 1'b0;
        ln_after = w_ln;
        // Pending token that the current byte cuts off.
        unique case (r_mode)
            M_WORD:    fl = mk(w_kw, '0, 8'd0, r_len, E_NONE, w_ln);
            M_NUM:     fl = mk(K_INT, r_acc, 8'd0, r_len, r_ovf ? E_OVERFLOW : E_NONE, w_ln);
            M_COLON:   fl = mk(K_COLON, '0, 8'd0, 8'd1, E_NONE, w_ln);
            M_LESS:    fl = mk(K_LT, '0, 8'd0, 8'd1, E_NONE, w_ln);
            M_GREATER: fl = mk(K_GT, '0, 8'd0, 8'd1, E_NONE, w_ln);
            M_STR:     fl = mk(K_ERROR, '0, 8'd0, 8'd0, E_NO_DQ, w_ln);
            M_CQ_OPEN: fl = mk(K_ERROR, '0, 8'd0, 8'd0, E_BAD_CHAR, w_ln);
            M_CQ_GOT:  fl = mk(K_ERROR, '0, 8'd0, 8'd0, E_NO_SQ, w_ln);
            default:   fl_v = 1'b0;
        endcase

        if (i_in.data.end_of_input) begin
            do_flush = 1'b1;
            st_v = 1'b1;
            st = mk(K_END, '0, 8'd0, 8'd0, E_NONE, w_ln);
            n_mode = M_IDLE; n_prefix = '0; n_len = '0; n_acc = '0;
            n_ovf = 1'b0; n_lit = '0; n_line = '0;
        end else begin
            unique case (r_mode)
                M_WORD: begin
                    if (is_let || is_dig) begin
                        for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
                            if (r_len == 8'(i)) n_prefix[i] = c_low;
                        end
                        n_len = w_lenp;
                    end else begin
                        do_flush = 1'b1; do_idle = 1'b1;
                    end
                end
                M_NUM: begin
                    if (is_dig) begin
                        if (w_sum > {5'd0, NUM_MAX}) begin
                            n_acc = NUM_MAX; n_ovf = 1'b1;
                        end else begin
                            n_acc = w_sum[30:0];
                        end
                        n_len = w_lenp;
                    end else begin
                        do_flush = 1'b1; do_idle = 1'b1;
                    end
                end
                M_COLON: begin
                    if (c == "=") begin
                        st_v = 1'b1; st = mk(K_ASSIGN, '0, 8'd0, 8'd2, E_NONE, w_ln);
                        n_mode = M_IDLE;
                    end else begin
                        do_flush = 1'b1; do_idle = 1'b1;
                    end
                end
                M_LESS: begin
                    if (c == "=" || c == ">") begin
                        st_v = 1'b1;
                        st = mk((c == "=") ? K_LE : K_NE, '0, 8'd0, 8'd2, E_NONE, w_ln);
                        n_mode = M_IDLE;
                    end else begin
                        do_flush = 1'b1; do_idle = 1'b1;
                    end
                end
                M_GREATER: begin
                    if (c == "=") begin
                        st_v = 1'b1; st = mk(K_GE, '0, 8'd0, 8'd2, E_NONE, w_ln);
                        n_mode = M_IDLE;
                    end else begin
                        do_flush = 1'b1; do_idle = 1'b1;
                    end
                end
                M_STR: begin
                    if (c == 8'd34) begin
                        st_v = 1'b1; st = mk(K_STR, '0, 8'd0, r_len, E_NONE, w_ln);
                        n_mode = M_IDLE;
                    end else if (is_prn) begin
                        n_len = w_lenp;
                    end else begin
                        do_flush = 1'b1; do_idle = 1'b1;
                    end
                end
                M_CQ_OPEN: begin
                    if (is_let || is_dig) begin
                        n_lit = c; n_mode = M_CQ_GOT;
                    end else begin
                        do_flush = 1'b1; do_idle = 1'b1;
                    end
                end
                M_CQ_GOT: begin
                    if (c == 8'd39) begin
                        st_v = 1'b1; st = mk(K_CHAR, '0, r_lit, 8'd1, E_NONE, w_ln);
                        n_mode = M_IDLE;
                    end else begin
                        do_flush = 1'b1; do_idle = 1'b1;
                    end
                end
                default: do_idle = 1'b1;
            endcase
            if (do_idle) begin
                // Start of a new token from idle.
                n_mode = M_IDLE;
                if (is_ws) begin
                    if (c == 8'd10 && r_line != 16'hFFFF) n_line = r_line + 16'd1;
                end else if (is_let) begin
                    n_prefix = '0; n_prefix[0] = c_low; n_len = 8'd1; n_mode = M_WORD;
                end else if (is_dig) begin
                    n_acc = {27'd0, c[3:0]}; n_ovf = 1'b0; n_len = 8'd1; n_mode = M_NUM;
                end else if (c == ":") n_mode = M_COLON;
                else if (c == "<") n_mode = M_LESS;
                else if (c == ">") n_mode = M_GREATER;
                else if (c == 8'd34) begin
                    n_len = 8'd0; n_mode = M_STR;
                end else if (c == 8'd39) n_mode = M_CQ_OPEN;
                else begin
                    st_v = 1'b1;
                    case (c)
                        "+": st = mk(K_SYM0 + 6'd0, '0, 8'd0, 8'd1, E_NONE, ln_after);
                        "-": st = mk(K_SYM0 + 6'd1, '0, 8'd0, 8'd1, E_NONE, ln_after);
                        "*": st = mk(K_SYM0 + 6'd2, '0, 8'd0, 8'd1, E_NONE, ln_after);
                        "/": st = mk(K_SYM0 + 6'd3, '0, 8'd0, 8'd1, E_NONE, ln_after);
                        ",": st = mk(K_SYM0 + 6'd4, '0, 8'd0, 8'd1, E_NONE, ln_after);
                        ";": st = mk(K_SYM0 + 6'd5, '0, 8'd0, 8'd1, E_NONE, ln_after);
                        "[": st = mk(K_SYM0 + 6'd6, '0, 8'd0, 8'd1, E_NONE, ln_after);
                        "(": st = mk(K_SYM0 + 6'd7, '0, 8'd0, 8'd1, E_NONE, ln_after);
                        "]": st = mk(K_SYM0 + 6'd8, '0, 8'd0, 8'd1, E_NONE, ln_after);
                        ")": st = mk(K_SYM0 + 6'd9, '0, 8'd0, 8'd1, E_NONE, ln_after);
                        "=": st = mk(K_SYM0 + 6'd10, '0, 8'd0, 8'd1, E_NONE, ln_after);
                        ".": st = mk(K_SYM0 + 6'd11, '0, 8'd0, 8'd1, E_NONE, ln_after);
                        default: st = mk(K_ERROR, '0, 8'd0, 8'd0, E_UNKNOWN, ln_after);
                    endcase
                end
            end
        end

        // Pack up to two results, the flushed token first.
        fl_v = fl_v && do_flush;
        w_r[0] = fl_v ? fl : st;
        w_r[1] = st;
        w_n = {1'b0, fl_v} + {1'b0, st_v};
        if (w_n == 2'd2) w_r[1].last = 1'b1;
        else w_r[0].last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_prefix <= '0; r_len <= '0; r_acc <= '0;
            r_ovf <= 1'b0; r_lit <= '0; r_line <= '0;
            r_v0 <= 1'b0; r_v1 <= 1'b0;
        end else begin
            if (w_acc) begin
                r_mode <= n_mode; r_prefix <= n_prefix; r_len <= n_len; r_acc <= n_acc;
                r_ovf <= n_ovf; r_lit <= n_lit; r_line <= n_line;
            end
            if (w_acc) begin
                // Both slots are free or about to be.
                r_v0 <= (w_n != 2'd0);
                r_v1 <= (w_n == 2'd2);
                r_o0 <= w_r[0];
                r_o1 <= w_r[1];
            end else if (r_v0 && o_out.ready) begin
                r_v0 <= r_v1;
                r_v1 <= 1'b0;
                r_o0 <= r_o1;
            end
        end
    end

    a_v1_needs_v0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> r_v0) else $error("second slot valid without first");
    a_no_take_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> !i_in.ready) else $error("item taken while two results wait");
    a_v1_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (r_o1.last && !r_o0.last)) else $error("last marker misplaced");
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.data.end_of_input) |=> (r_mode == M_IDLE && r_line == 16'd0))
        else $error("end of input did not clear state");
endmodule
